>>> rtl/integer_array_sorter_defines.svh
// -----------------------------------------------------------------------------
// integer_array_sorter_defines.svh
// assertion macros used by the sorter rtl
// -----------------------------------------------------------------------------
`ifndef INTEGER_ARRAY_SORTER_DEFINES_SVH
`define INTEGER_ARRAY_SORTER_DEFINES_SVH

// clocked property check with async active-low reset as disable
`define IAS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be seen at a clock edge
`define IAS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  `IAS_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

>>> rtl/ias_pkg.sv
// -----------------------------------------------------------------------------
// ias_pkg
// shared types for the integer array sorter
// -----------------------------------------------------------------------------
package ias_pkg;

  localparam int unsigned ValueWidth = 32;

  typedef struct packed {
    logic [ValueWidth-1:0] value;
    logic                  last;
  } in_item_t;

  typedef struct packed {
    logic [ValueWidth-1:0] sorted_value;
    logic                  final_res;
    logic                  overflow;
  } out_item_t;

  // one element slot, held in a cell or travelling between cells
  typedef struct packed {
    logic                  valid;
    logic [ValueWidth-1:0] value;
  } slot_t;

endpackage

>>> rtl/ias_cell.sv
// -----------------------------------------------------------------------------
// ias_cell
// one insertion cell: keeps the smaller value, passes the larger one on
// -----------------------------------------------------------------------------
module ias_cell
  import ias_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  slot_t carry_i,   // value arriving from the previous cell
  output slot_t carry_o,   // registered value handed to the next cell
  input  logic  shift_i,   // drain: take the neighbor's held value
  input  slot_t shift_in_i,
  output slot_t held_o
);

  slot_t held_q, held_d;
  slot_t carry_q, carry_d;

  always_comb begin
    held_d  = held_q;
    carry_d = '0;
    if (carry_i.valid) begin
      if (!held_q.valid) begin
        held_d = carry_i;
      end else if ($signed(carry_i.value) < $signed(held_q.value)) begin
        held_d  = carry_i;
        carry_d = held_q;
      end else begin
        carry_d = carry_i;
      end
    end
    if (shift_i) begin
      held_d = shift_in_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= '0;
      carry_q <= '0;
    end else begin
      held_q  <= held_d;
      carry_q <= carry_d;
    end
  end

  assign carry_o = carry_q;
  assign held_o  = held_q;

endmodule

>>> rtl/integer_array_sorter.sv
// -----------------------------------------------------------------------------
// integer_array_sorter
// systolic insertion sorter for sets of signed 32-bit integers
// -----------------------------------------------------------------------------
// usage
//   input channel: in_valid_i / in_ready_o with in_item_i (value, last).
//   one item per cycle is taken while a set is being collected; the item
//   with last set closes the set.
//   each element enters cell 0 and the displaced larger values ripple down
//   the chain of MAX_ELEMENTS cells, one cell per cycle.
//   after the last item the block settles until no value is still moving
//   down the chain, and in_ready_o stays low.
//   it then shows the n values in ascending signed order on out_valid_o /
//   out_ready_i, one per cycle while the receiver takes them; final_res
//   marks the largest, overflow marks a set that lost items to a full chain.
//   a stalled receiver simply holds the current item; the chain only shifts
//   toward cell 0 when an item is taken.
//   after the final item is taken a new set may start in the next cycle.
//   reset empties the chain and the count; no clearing pass is needed.
// -----------------------------------------------------------------------------
`include "integer_array_sorter_defines.svh"

module integer_array_sorter
  import ias_pkg::*;
#(
  parameter int unsigned MAX_ELEMENTS = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  localparam int unsigned CountWidth = $clog2(MAX_ELEMENTS + 1);

  localparam logic [1:0] ST_COLLECT = 2'd0;
  localparam logic [1:0] ST_SETTLE  = 2'd1;
  localparam logic [1:0] ST_DRAIN   = 2'd2;

  logic [1:0]            state_q, state_d;
  logic [CountWidth-1:0] count_q, count_d;
  logic                  ovf_q, ovf_d;

  logic in_acc, out_acc, room, moving;

  // carry_w[i] enters cell i; held_w[i] is what cell i keeps
  slot_t                  carry_w [MAX_ELEMENTS];
  slot_t                  held_w  [MAX_ELEMENTS];
  slot_t                  carry_end;
  logic [MAX_ELEMENTS-1:0] carry_vld;

  assign in_ready_o  = (state_q == ST_COLLECT);
  assign out_valid_o = (state_q == ST_DRAIN);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_acc     = out_valid_o && out_ready_i;
  assign room        = (count_q < CountWidth'(MAX_ELEMENTS));
  assign moving      = |carry_vld;

  // new element goes straight into the head cell
  assign carry_w[0].valid = in_acc && room;
  assign carry_w[0].value = in_item_i.value;

  for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_chain
    slot_t carry_out, shift_src;

    if (i < MAX_ELEMENTS - 1) begin : g_mid
      assign carry_w[i+1] = carry_out;
      assign shift_src    = held_w[i+1];
    end else begin : g_tail
      assign carry_end = carry_out;
      assign shift_src = '0;
    end

    assign carry_vld[i] = carry_out.valid;

    ias_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .carry_i    (carry_w[i]),
      .carry_o    (carry_out),
      .shift_i    (out_acc),
      .shift_in_i (shift_src),
      .held_o     (held_w[i])
    );
  end

  // control: collect, wait for ripples to die out, drain from the head
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    ovf_d   = ovf_q;
    unique case (state_q)
      ST_COLLECT: begin
        if (in_acc) begin
          if (room) begin
            count_d = count_q + CountWidth'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (in_item_i.last) begin
            state_d = ST_SETTLE;
          end
        end
      end
      ST_SETTLE: begin
        if (!moving) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (out_acc) begin
          count_d = count_q - CountWidth'(1);
          if (count_q == CountWidth'(1)) begin
            state_d = ST_COLLECT;
            ovf_d   = 1'b0;
          end
        end
      end
      default: begin
        state_d = ST_COLLECT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_COLLECT;
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

  // head cell holds the smallest remaining value
  assign out_item_o.sorted_value = held_w[0].value;
  assign out_item_o.final_res    = (count_q == CountWidth'(1));
  assign out_item_o.overflow     = ovf_q;

  `IAS_ASSERT(a_drain_settled, clk_i, rst_ni, out_valid_o |-> !moving,
    "result shown while values still move down the chain")
  `IAS_ASSERT(a_head_valid, clk_i, rst_ni, out_valid_o |-> held_w[0].valid,
    "result shown from an empty head cell")
  `IAS_ASSERT_NEVER(a_no_spill, clk_i, rst_ni, carry_end.valid,
    "value pushed off the end of the chain")
  `IAS_ASSERT(a_final_reopens, clk_i, rst_ni,
    (out_acc && out_item_o.final_res) |=> (in_ready_o && count_q == '0),
    "set not closed after its final item")

endmodule
